// ===== rtl/core/sckt_pkg.sv =====
// sckt_pkg: types and constants for the sorted counted key table
// no dependencies
package sckt_pkg;
  localparam int unsigned TableDepth = 8192;
  localparam int unsigned AddrBits = 13;
  localparam int unsigned FillBits = 14;
  localparam int unsigned CountBits = 16;
  localparam int unsigned KeyBits = 192;
  localparam int unsigned KeyBytes = 24;

  localparam logic [1:0] StPresent = 2'd0;
  localparam logic [1:0] StAdded = 2'd1;
  localparam logic [1:0] StAbsent = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  localparam logic ModeAdd = 1'b0;
  localparam logic ModeTake = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_CHECK,
    S_DECIDE,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SHDN_RD,
    S_SHDN_WR,
    S_WRITE,
    S_DONE
  } state_t;

  // zero every byte after the first zero byte and past the key length
  function automatic logic [KeyBits-1:0] tidy_key(input logic [KeyBits-1:0] k);
    logic [KeyBits-1:0] r;
    logic ended;
    r = k;
    ended = 1'b0;
    for (int i = 0; i < 24; i++) begin
      if (i >= KeyBytes || k[KeyBits-1-8*i -: 8] == 8'd0) ended = 1'b1;
      if (ended) r[KeyBits-1-8*i -: 8] = 8'd0;
    end
    return r;
  endfunction
endpackage

// ===== rtl/core/sckt_if.sv =====
// sckt_req_if, sckt_rsp_if: valid/ready channels for request and result words
// depends on nothing
interface sckt_req_if;
  logic valid;
  logic ready;
  logic mode;
  logic [63:0] key_high;
  logic [63:0] key_middle;
  logic [63:0] key_low;
  modport source(output valid, mode, key_high, key_middle, key_low, input ready);
  modport sink(input valid, mode, key_high, key_middle, key_low, output ready);
endinterface

interface sckt_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [15:0] count_after;
  logic [13:0] entries_used;
  modport source(output valid, status, count_after, entries_used, input ready);
  modport sink(input valid, status, count_after, entries_used, output ready);
endinterface

// ===== rtl/core/sorted_counted_key_table_core.sv =====
// sorted_counted_key_table_core: sorted key table with counts in one memory
// depends on sckt_pkg and the channel interfaces in sckt_if.sv
// steps: a binary search of up to 14 probes (S_PROBE read, S_CMP compare), then S_CHECK,
//   S_DECIDE and, on insert or removal, a shift that reads then writes each moved entry
// one word at a time; the next word waits until the result word is taken
// reset: fill level cleared, no memory clearing pass, ready after reset
module sorted_counted_key_table_core (
  input  logic clk,
  input  logic rst_n,
  sckt_req_if.sink in_ch,
  sckt_rsp_if.source out_ch
);
  localparam int unsigned EntBits = sckt_pkg::KeyBits + sckt_pkg::CountBits;

  // entry memory: key over count
  logic [EntBits-1:0] mem [sckt_pkg::TableDepth];
  logic [EntBits-1:0] rd_data_r;
  logic [sckt_pkg::AddrBits-1:0] rd_addr;
  logic rd_en;
  logic [sckt_pkg::AddrBits-1:0] wr_addr;
  logic [EntBits-1:0] wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  sckt_pkg::state_t state_r, state_nxt;
  logic mode_r;
  logic [sckt_pkg::KeyBits-1:0] key_r;
  logic [sckt_pkg::FillBits-1:0] fill_r, lo_r, hi_r, ptr_r;
  logic [sckt_pkg::FillBits-1:0] mid;
  logic [sckt_pkg::FillBits:0] mid_sum;
  logic [sckt_pkg::CountBits-1:0] cnt_r;
  logic [1:0] status_r;
  logic [sckt_pkg::CountBits-1:0] count_out_r;
  logic out_valid_r;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid = mid_sum[sckt_pkg::FillBits:1];

  logic [sckt_pkg::KeyBits-1:0] rd_key;
  logic [sckt_pkg::CountBits-1:0] rd_cnt;
  assign rd_key = rd_data_r[EntBits-1 -: sckt_pkg::KeyBits];
  assign rd_cnt = rd_data_r[sckt_pkg::CountBits-1:0];

  logic found;
  assign found = (lo_r < fill_r) && (rd_key == key_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sckt_pkg::S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = sckt_pkg::S_PROBE;
      sckt_pkg::S_PROBE: state_nxt = (lo_r < hi_r) ? sckt_pkg::S_CMP : sckt_pkg::S_CHECK;
      sckt_pkg::S_CMP: state_nxt = sckt_pkg::S_PROBE;
      sckt_pkg::S_CHECK: state_nxt = sckt_pkg::S_DECIDE;
      sckt_pkg::S_DECIDE: begin
        if (found) begin
          if (mode_r == sckt_pkg::ModeTake && rd_cnt == sckt_pkg::CountBits'(1))
            state_nxt = sckt_pkg::S_SHDN_RD;
          else state_nxt = sckt_pkg::S_WRITE;
        end else if (mode_r == sckt_pkg::ModeTake) state_nxt = sckt_pkg::S_DONE;
        else if (fill_r == sckt_pkg::FillBits'(sckt_pkg::TableDepth))
          state_nxt = sckt_pkg::S_DONE;
        else state_nxt = sckt_pkg::S_SHUP_RD;
      end
      sckt_pkg::S_SHUP_RD:
        state_nxt = (ptr_r == lo_r) ? sckt_pkg::S_WRITE : sckt_pkg::S_SHUP_WR;
      sckt_pkg::S_SHUP_WR: state_nxt = sckt_pkg::S_SHUP_RD;
      sckt_pkg::S_SHDN_RD:
        state_nxt = (ptr_r + 1'b1 >= fill_r) ? sckt_pkg::S_DONE : sckt_pkg::S_SHDN_WR;
      sckt_pkg::S_SHDN_WR: state_nxt = sckt_pkg::S_SHDN_RD;
      sckt_pkg::S_WRITE: state_nxt = sckt_pkg::S_DONE;
      sckt_pkg::S_DONE: if (!out_valid_r) state_nxt = sckt_pkg::S_IDLE;
      default: state_nxt = sckt_pkg::S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    rd_en = 1'b0;
    rd_addr = mid[sckt_pkg::AddrBits-1:0];
    wr_en = 1'b0;
    wr_addr = ptr_r[sckt_pkg::AddrBits-1:0];
    wr_data = rd_data_r;
    unique case (state_r)
      sckt_pkg::S_PROBE: begin
        rd_en = 1'b1;
        rd_addr = (lo_r < hi_r) ? mid[sckt_pkg::AddrBits-1:0] : lo_r[sckt_pkg::AddrBits-1:0];
      end
      sckt_pkg::S_SHUP_RD: begin
        rd_en = 1'b1;
        rd_addr = ptr_r[sckt_pkg::AddrBits-1:0] - 1'b1;
      end
      sckt_pkg::S_SHUP_WR: wr_en = 1'b1;
      sckt_pkg::S_SHDN_RD: begin
        rd_en = 1'b1;
        rd_addr = ptr_r[sckt_pkg::AddrBits-1:0] + 1'b1;
      end
      sckt_pkg::S_SHDN_WR: wr_en = 1'b1;
      sckt_pkg::S_WRITE: begin
        wr_en = 1'b1;
        wr_addr = lo_r[sckt_pkg::AddrBits-1:0];
        wr_data = {key_r, cnt_r};
      end
      default: ;
    endcase
  end

  // accept only when idle and the previous result word has left
  assign in_ch.ready = (state_r == sckt_pkg::S_IDLE) && !out_valid_r;

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sckt_pkg::S_IDLE;
      fill_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        sckt_pkg::S_IDLE: if (in_ch.valid && in_ch.ready) begin
          mode_r <= in_ch.mode;
          key_r <= sckt_pkg::tidy_key({in_ch.key_high, in_ch.key_middle, in_ch.key_low});
          lo_r <= '0;
          hi_r <= fill_r;
        end
        sckt_pkg::S_CMP: begin
          if (rd_key < key_r) lo_r <= mid + 1'b1;
          else hi_r <= mid;
        end
        sckt_pkg::S_DECIDE: begin
          if (found) begin
            status_r <= sckt_pkg::StPresent;
            if (mode_r == sckt_pkg::ModeAdd)
              cnt_r <= (&rd_cnt) ? rd_cnt : rd_cnt + 1'b1;
            else cnt_r <= rd_cnt - 1'b1;
            if (mode_r == sckt_pkg::ModeTake && rd_cnt == sckt_pkg::CountBits'(1)) begin
              ptr_r <= lo_r;
              count_out_r <= '0;
            end else if (mode_r == sckt_pkg::ModeAdd)
              count_out_r <= (&rd_cnt) ? rd_cnt : rd_cnt + 1'b1;
            else count_out_r <= rd_cnt - 1'b1;
          end else begin
            count_out_r <= '0;
            if (mode_r == sckt_pkg::ModeTake) status_r <= sckt_pkg::StAbsent;
            else if (fill_r == sckt_pkg::FillBits'(sckt_pkg::TableDepth))
              status_r <= sckt_pkg::StFull;
            else begin
              status_r <= sckt_pkg::StAdded;
              cnt_r <= sckt_pkg::CountBits'(1);
              count_out_r <= sckt_pkg::CountBits'(1);
              ptr_r <= fill_r;
            end
          end
        end
        sckt_pkg::S_SHUP_RD: if (ptr_r == lo_r) fill_r <= fill_r + 1'b1;
        sckt_pkg::S_SHUP_WR: ptr_r <= ptr_r - 1'b1;
        sckt_pkg::S_SHDN_RD: if (ptr_r + 1'b1 >= fill_r) fill_r <= fill_r - 1'b1;
        sckt_pkg::S_SHDN_WR: ptr_r <= ptr_r + 1'b1;
        sckt_pkg::S_DONE: if (!out_valid_r) out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // result channel
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.count_after = count_out_r;
  assign out_ch.entries_used = fill_r;
endmodule
